// File: src/kpmd_pkg.sv
// Package for the key PC miss detector: field widths, limits and defaults.
`timescale 1ns / 1ps
`default_nettype none

package kpmd_pkg;

    // Payload and counter widths
    localparam int PC_W    = 64;
    localparam int ISSUE_W = 16;
    localparam int MISS_W  = 10;

    // Default table depth
    localparam int ENTRIES_DEF = 16;

    // Counter limits
    localparam logic [MISS_W-1:0]  CLEAR_LIMIT = 10'd511;
    localparam logic [ISSUE_W-1:0] ISSUE_MAX   = 16'hFFFF;

endpackage

`default_nettype wire

// File: src/key_pc_miss_detector.sv
// Top level of the key PC miss detector: tag CAM, per-PC counters and decision.
`timescale 1ns / 1ps
`default_nettype none

// Takes one load access (PC and hit flag) per request and returns one is_key
// result per request. A request is accepted every cycle while the result side
// keeps up; a result passes through the input register and then the result
// register before it leaves. The CAM compare of all ENTRIES tags and the
// counter update of the matching slot both act on the request held in the
// input register, which also makes each request see the state left by the one
// before it. New PCs replace the oldest slot in FIFO order. Once the global miss
// total exceeds 511, all issue and miss counters clear; tags and valid bits stay.
module key_pc_miss_detector
    import kpmd_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    // Request channel
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [PC_W-1:0] i_pc,
    input  wire logic            i_was_hit,
    // Result channel
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic                 o_is_key
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Input register
    logic              r_in_v;
    logic [PC_W-1:0]   r_pc;
    logic              r_miss;

    // Result register
    logic              r_out_v;
    logic              r_is_key;

    // Table state
    logic [PC_W-1:0]    r_tag    [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [ISSUE_W-1:0] r_issues [ENTRIES];
    logic [MISS_W-1:0]  r_misses [ENTRIES];
    logic [MISS_W-1:0]  r_gmiss;
    logic [IDX_W-1:0]   r_oldest;

    // Decision signals
    logic               w_adv;
    logic [ENTRIES-1:0] w_match;
    logic               w_hit;
    logic [IDX_W-1:0]   w_hit_idx;
    logic [ISSUE_W-1:0] w_cur_issues;
    logic [MISS_W-1:0]  w_cur_misses;
    logic [IDX_W-1:0]   w_slot;
    logic               w_clear;
    logic               w_key_ratio;
    logic               w_key_share;
    logic [ISSUE_W-1:0] n_issues;
    logic [MISS_W-1:0]  n_misses;
    logic [MISS_W-1:0]  n_gmiss;
    logic [IDX_W-1:0]   n_oldest;
    logic               n_is_key;

    // Advance the held request when the result register is free or draining
    assign w_adv   = r_in_v && (!r_out_v || i_ready);
    assign o_ready = !r_in_v || w_adv;
    assign o_valid = r_out_v;
    assign o_is_key = r_is_key;

    // Compare the PC against every valid tag; read the matching slot's counters
    always_comb begin
        w_hit_idx    = '0;
        w_cur_issues = '0;
        w_cur_misses = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_tag[i] == r_pc);
            if (w_match[i]) begin
                w_hit_idx    = w_hit_idx | IDX_W'(i);
                w_cur_issues = w_cur_issues | r_issues[i];
                w_cur_misses = w_cur_misses | r_misses[i];
            end
        end
        w_hit = |w_match;
    end

    // Compute updated counters and the key decision
    always_comb begin
        w_slot   = w_hit ? w_hit_idx : r_oldest;
        n_oldest = (r_oldest == LAST_IDX) ? '0 : r_oldest + 1'b1;
        n_gmiss  = r_gmiss + MISS_W'(r_miss);
        w_clear  = n_gmiss > CLEAR_LIMIT;
        if (w_hit) begin
            n_issues = (w_cur_issues == ISSUE_MAX) ? w_cur_issues : w_cur_issues + 1'b1;
            n_misses = w_cur_misses + MISS_W'(r_miss);
        end else begin
            n_issues = ISSUE_W'(1);
            n_misses = MISS_W'(r_miss);
        end
        w_key_ratio = {6'b0, n_misses, 1'b0} > {1'b0, n_issues};
        w_key_share = {n_misses, 3'b0} > {3'b0, n_gmiss};
        n_is_key    = w_hit ? (w_key_ratio || w_key_share) : r_miss;
    end

    // Hold the request in the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_ready) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pc   <= i_pc;
            r_miss <= !i_was_hit;
        end
    end

    // Load the result register; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_is_key <= n_is_key;
        end
    end

    // Write the new tag into the oldest slot
    always_ff @(posedge i_clk) begin
        if (w_adv && !w_hit) begin
            r_tag[r_oldest] <= r_pc;
        end
    end

    // Update valid bits, FIFO pointer and counters; clear counters past the limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_gmiss  <= '0;
            r_oldest <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_issues[i] <= '0;
                r_misses[i] <= '0;
            end
        end else if (w_adv) begin
            if (!w_hit) begin
                r_valid[r_oldest] <= 1'b1;
                r_oldest          <= n_oldest;
            end
            if (w_clear) begin
                r_gmiss <= '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    r_issues[i] <= '0;
                    r_misses[i] <= '0;
                end
            end else begin
                r_gmiss          <= n_gmiss;
                r_issues[w_slot] <= n_issues;
                r_misses[w_slot] <= n_misses;
            end
        end
    end

`ifndef SYNTHESIS
    // Valid tags are unique, so at most one slot matches
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_v |-> $onehot0(w_match))
        else $error("more than one table slot matches the request PC");

    // The global miss total never stays above the clear limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gmiss <= CLEAR_LIMIT)
        else $error("global miss total above clear limit");

    // A new PC that missed is reported as key
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_hit && r_miss) |=> (o_valid && o_is_key))
        else $error("missing new PC not reported as key");

    // A request entering the table makes that slot valid
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_hit) |=> (r_valid[$past(r_oldest)] && o_valid))
        else $error("inserted slot not valid");
`endif

endmodule

`default_nettype wire
